FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the top-level RTL file of the queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/cqir_pkg.sv
// ----------------------------------------------------------------------------
// cqir_pkg
// Types and constants of the circular queue with indexed read.
// ----------------------------------------------------------------------------
package cqir_pkg;

  // Depth must be a power of two so that the pointers wrap by themselves.
  localparam int unsigned Depth     = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned TypeW     = 2;
  localparam int unsigned PosW      = 6;
  localparam int unsigned StatW     = 2;
  localparam int unsigned OccW      = 7;

  typedef enum logic [TypeW-1:0] {
    REQ_PUSH      = 2'd0,
    REQ_POP       = 2'd1,
    REQ_READ_POS  = 2'd2,
    REQ_READ_TAIL = 2'd3
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [AddrW-1:0]     addr;
    logic [DataWidth-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic            rd;
    status_e         status;
    logic [OccW-1:0] occupancy;
    logic            is_empty;
  } result_t;

endpackage

FILE: rtl/cqir_if.sv
// ----------------------------------------------------------------------------
// cqir_req_if / cqir_rsp_if
// Valid/ready channels for requests and results of the queue.
// ----------------------------------------------------------------------------
interface cqir_req_if import cqir_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TypeW-1:0]     req_type;
  logic [DataWidth-1:0] push_data;
  logic [PosW-1:0]      position;

  modport source (output valid, req_type, push_data, position, input ready);
  modport sink   (input valid, req_type, push_data, position, output ready);
endinterface

interface cqir_rsp_if import cqir_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] read_data;
  logic [StatW-1:0]     status;
  logic [OccW-1:0]      occupancy;
  logic                 is_empty;

  modport source (output valid, read_data, status, occupancy, is_empty, input ready);
  modport sink   (input valid, read_data, status, occupancy, is_empty, output ready);
endinterface

FILE: rtl/circular_queue_with_indexed_read.sv
// ----------------------------------------------------------------------------
// circular_queue_with_indexed_read
// Ring-buffer FIFO with push, pop, positional read and tail read.
// ----------------------------------------------------------------------------
// The queue takes one request in every cycle unless the output register is
// stalled by rsp_o.ready, and returns one result for each, in order. A result
// passes from the registered read of the single-port entry memory (and the
// stage-1 result register) into the output register. The entry memory has one
// port, used by a push to write or by a read request to read, so each request
// needs at most one access. The memory is not cleared after reset; only pushed
// entries can be read. A push into a full queue is dropped with status full, a
// request that needs an entry of an empty queue returns status empty, and a
// positional read at or past the occupancy returns status out of range.
`include "assert_macros.svh"

module circular_queue_with_indexed_read import cqir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cqir_req_if.sink    req_i,
  cqir_rsp_if.source  rsp_o
);

  logic                 accept;
  logic                 s1_adv;
  logic                 s1_valid_q, s1_valid_d;
  result_t              s1_result_q;
  result_t              result;
  mem_req_t             mem_req;
  logic [DataWidth-1:0] mem_rdata;
  logic                 rsp_valid_q, rsp_valid_d;
  logic [DataWidth-1:0] read_data_q;
  logic [StatW-1:0]     status_q;
  logic [OccW-1:0]      occupancy_q;
  logic                 is_empty_q;

  assign s1_adv      = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept      = req_i.valid && req_i.ready;

  cqir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_i.req_type),
    .push_data_i (req_i.push_data),
    .position_i  (req_i.position),
    .mem_req_o   (mem_req),
    .result_o    (result)
  );

  cqir_ram #(
    .NumWords (Depth),
    .WordW    (DataWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    rsp_valid_d = rsp_valid_q;
    if (s1_adv) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_result_q <= result;
    end
    if (s1_adv) begin
      read_data_q <= s1_result_q.rd ? mem_rdata : '0;
      status_q    <= s1_result_q.status;
      occupancy_q <= s1_result_q.occupancy;
      is_empty_q  <= s1_result_q.is_empty;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_data = read_data_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.occupancy = occupancy_q;
  assign rsp_o.is_empty  = is_empty_q;

  `ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, accept, s1_valid_q)
  `ASSERT_IMPL(a_full_occupancy, clk_i, rst_ni, rsp_o.valid && (rsp_o.status == ST_FULL), rsp_o.occupancy == OccW'(Depth))
  `ASSERT_IMPL(a_fail_zero_data, clk_i, rst_ni, rsp_o.valid && (rsp_o.status != ST_OK), rsp_o.read_data == '0)
  `ASSERT_IMPL(a_empty_flag, clk_i, rst_ni, rsp_o.valid, rsp_o.is_empty == (rsp_o.occupancy == '0))

endmodule

FILE: rtl/cqir_ram.sv
// ----------------------------------------------------------------------------
// cqir_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cqir_ram #(
  parameter int unsigned NumWords = 64,
  parameter int unsigned WordW    = 32,
  localparam int unsigned AddrW   = $clog2(NumWords)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WordW-1:0] wdata_i,
  output logic [WordW-1:0] rdata_o
);

  logic [WordW-1:0] mem_q [NumWords];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cqir_ctrl.sv
// ----------------------------------------------------------------------------
// cqir_ctrl
// Head, tail and count registers; decodes a request into a memory access
// and the status and occupancy of its result.
// ----------------------------------------------------------------------------
module cqir_ctrl import cqir_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [TypeW-1:0]     req_type_i,
  input  logic [DataWidth-1:0] push_data_i,
  input  logic [PosW-1:0]      position_i,
  output mem_req_t             mem_req_o,
  output result_t              result_o
);

  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] slot;
  logic             empty;
  logic             full;
  status_e          status;
  logic             rd;

  assign empty = (count_q == '0);
  assign full  = (count_q == CntW'(Depth));
  assign slot  = empty ? head_q : tail_q + AddrW'(1);

  always_comb begin
    head_d          = head_q;
    tail_d          = tail_q;
    count_d         = count_q;
    status          = ST_OK;
    rd              = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.addr  = tail_q;
    mem_req_o.wdata = push_data_i;
    unique case (req_e'(req_type_i))
      REQ_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mem_req_o.we   = accept_i;
          mem_req_o.addr = slot;
          tail_d         = slot;
          count_d        = count_q + CntW'(1);
        end
      end
      REQ_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          head_d  = head_q + AddrW'(1);
          count_d = count_q - CntW'(1);
        end
      end
      REQ_READ_POS: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (CntW'(position_i) >= count_q) begin
          status = ST_RANGE;
        end else begin
          rd             = 1'b1;
          mem_req_o.re   = accept_i;
          mem_req_o.addr = head_q + AddrW'(position_i);
        end
      end
      REQ_READ_TAIL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd           = 1'b1;
          mem_req_o.re = accept_i;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign result_o.rd        = rd;
  assign result_o.status    = status;
  assign result_o.occupancy = OccW'(count_d);
  assign result_o.is_empty  = (count_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule
